// ----- rtl/core/serial_command_port_parser_macros.svh -----
// Assertion helpers for the serial command port parser.
`ifndef SERIAL_COMMAND_PORT_PARSER_MACROS_SVH
`define SERIAL_COMMAND_PORT_PARSER_MACROS_SVH

// Check that cons follows ante in the same cycle.
`define SCP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define SCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/scp_pkg.sv -----
`default_nettype none
package scp_pkg;

	localparam int LINE_CHARS_DEF = 16;

	// Command and argument characters
	localparam logic [7:0] CH_L  = 8'h6C; // 'l'
	localparam logic [7:0] CH_T  = 8'h74; // 't'
	localparam logic [7:0] CH_C  = 8'h63; // 'c'
	localparam logic [7:0] CH_0  = 8'h30; // '0'
	localparam logic [7:0] CH_1  = 8'h31; // '1'
	localparam logic [7:0] CH_2  = 8'h32; // '2'
	localparam logic [7:0] CH_5  = 8'h35; // '5'
	localparam logic [7:0] CH_7  = 8'h37; // '7'
	localparam logic [7:0] CH_UC = 8'h43; // 'C'
	localparam logic [7:0] CH_UD = 8'h44; // 'D'
	localparam logic [7:0] CH_UB = 8'h42; // 'B'

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LINE  = 3'd1,
		PH_CHARS = 3'd2,
		PH_DUTY1 = 3'd3,
		PH_DUTY2 = 3'd4,
		PH_PORT  = 3'd5,
		PH_BIT   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ACT_LINE = 3'd0,
		ACT_CHAR = 3'd1,
		ACT_TX   = 3'd2,
		ACT_DUTY = 3'd3,
		ACT_PINS = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		PORT_C = 2'd0,
		PORT_D = 2'd1,
		PORT_B = 2'd2
	} port_sel_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [9:0] conv_reading;
	} in_item_t;

	typedef struct packed {
		action_t    action;
		logic       line_number;
		logic [7:0] data_byte;
		logic [8:0] duty_value;
		logic [7:0] port_d_pins;
		logic [7:0] port_b_pins;
		logic       pin_c5;
	} out_item_t;

	// Parser state apart from the character counter
	typedef struct packed {
		phase_t     phase;
		logic       set_not_clear;
		port_sel_t  port_choice;
		logic [7:0] duty_first_byte;
		logic [7:0] d_levels;
		logic [7:0] b_levels;
		logic       c5_level;
	} parse_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/serial_command_port_parser.sv -----
// An accepted byte goes into the input register, then its result into the result register.
// Throughput: one byte per cycle while out_ready stays high.
// A stalled result holds the decode stage; in_ready then drops in the same cycle.
// Reset (arst_n low, asynchronous) returns the parser to idle and clears all pin levels.
`default_nettype none
`include "serial_command_port_parser_macros.svh"
module serial_command_port_parser
	import scp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	localparam int CHARS_W = $clog2(LINE_CHARS + 1);

	logic               valid_s1;
	in_item_t           item_s1;
	parse_state_t       state_q;
	parse_state_t       state_next;
	logic [CHARS_W-1:0] chars_left_q;
	logic [CHARS_W-1:0] chars_left_next;
	logic               res_valid;
	out_item_t          res;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	scp_decode #(
		.LINE_CHARS(LINE_CHARS)
	) u_decode (
		.cur             (state_q),
		.chars_left      (chars_left_q),
		.item            (item_s1),
		.nxt             (state_next),
		.chars_left_next (chars_left_next),
		.res_valid       (res_valid),
		.res             (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_IDLE;
			state_q.set_not_clear   <= 1'b0;
			state_q.port_choice     <= PORT_C;
			state_q.duty_first_byte <= 8'h00;
			state_q.d_levels        <= 8'h00;
			state_q.b_levels        <= 8'h00;
			state_q.c5_level        <= 1'b0;
			chars_left_q            <= '0;
		end else if (advance) begin
			state_q      <= state_next;
			chars_left_q <= chars_left_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SCP_ASSERT_IMPL(a_chars_nonzero, state_q.phase == PH_CHARS, chars_left_q != '0)
	`SCP_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1 && $stable(item_s1))
	`SCP_ASSERT_NEXT(a_duty_result, advance && state_q.phase == PH_DUTY2,
		out_valid_q && out_q.action == ACT_DUTY && state_q.phase == PH_IDLE)

endmodule
`default_nettype wire

// ----- rtl/core/scp_decode.sv -----
`default_nettype none
module scp_decode
	import scp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input  wire parse_state_t                          cur,
	input  wire logic [$clog2(LINE_CHARS + 1) - 1:0]   chars_left,
	input  wire in_item_t                              item,
	output parse_state_t                               nxt,
	output logic [$clog2(LINE_CHARS + 1) - 1:0]        chars_left_next,
	output logic                                       res_valid,
	output out_item_t                                  res
);

	localparam int CHARS_W = $clog2(LINE_CHARS + 1);

	logic [7:0]         rx;
	logic [7:0]         bit_mask;
	logic               bit_ok;
	logic [CHARS_W-1:0] chars_dec;

	assign rx        = item.rx_byte;
	assign chars_dec = chars_left - CHARS_W'(1);

	always_comb begin
		bit_mask = 8'h00;
		bit_ok   = 1'b0;
		if (rx == CH_T) begin
			bit_mask = 8'hFF;
			bit_ok   = 1'b1;
		end else if (rx inside {[CH_0:CH_7]}) begin
			bit_mask = 8'h01 << rx[2:0];
			bit_ok   = 1'b1;
		end
	end

	// Next state
	always_comb begin
		nxt             = cur;
		chars_left_next = chars_left;
		case (cur.phase)
			PH_LINE: begin
				if (rx == CH_1 || rx == CH_2) begin
					nxt.phase       = PH_CHARS;
					chars_left_next = CHARS_W'(LINE_CHARS);
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_CHARS: begin
				chars_left_next = chars_dec;
				if (chars_dec == '0)
					nxt.phase = PH_IDLE;
			end
			PH_DUTY1: begin
				nxt.duty_first_byte = rx;
				nxt.phase           = PH_DUTY2;
			end
			PH_DUTY2: nxt.phase = PH_IDLE;
			PH_PORT: begin
				if (rx == CH_UC) begin
					nxt.port_choice = PORT_C;
					nxt.phase       = PH_BIT;
				end else if (rx == CH_UD) begin
					nxt.port_choice = PORT_D;
					nxt.phase       = PH_BIT;
				end else if (rx == CH_UB) begin
					nxt.port_choice = PORT_B;
					nxt.phase       = PH_BIT;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_BIT: begin
				nxt.phase = PH_IDLE;
				if (cur.port_choice == PORT_C) begin
					if (rx == CH_5)
						nxt.c5_level = cur.set_not_clear;
				end else if (bit_ok) begin
					if (cur.port_choice == PORT_D)
						nxt.d_levels = cur.set_not_clear ? (cur.d_levels | bit_mask)
							: (cur.d_levels & ~bit_mask);
					else
						nxt.b_levels = cur.set_not_clear ? (cur.b_levels | bit_mask)
							: (cur.b_levels & ~bit_mask);
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
				if (rx == CH_L) begin
					nxt.phase = PH_LINE;
				end else if (rx == CH_C) begin
					nxt.phase = PH_DUTY1;
				end else if (rx == CH_1 || rx == CH_0) begin
					nxt.set_not_clear = (rx == CH_1);
					nxt.phase         = PH_PORT;
				end
			end
		endcase
	end

	// Result
	always_comb begin
		res_valid       = 1'b0;
		res.action      = ACT_LINE;
		res.line_number = 1'b0;
		res.data_byte   = 8'h00;
		res.duty_value  = 9'h000;
		res.port_d_pins = nxt.d_levels;
		res.port_b_pins = nxt.b_levels;
		res.pin_c5      = nxt.c5_level;
		case (cur.phase)
			PH_LINE: begin
				if (rx == CH_1 || rx == CH_2) begin
					res_valid       = 1'b1;
					res.action      = ACT_LINE;
					res.line_number = (rx == CH_2);
				end
			end
			PH_CHARS: begin
				res_valid     = 1'b1;
				res.action    = ACT_CHAR;
				res.data_byte = rx;
			end
			PH_DUTY1: res_valid = 1'b0;
			PH_DUTY2: begin
				res_valid      = 1'b1;
				res.action     = ACT_DUTY;
				res.duty_value = {1'b0, cur.duty_first_byte} + {1'b0, rx};
			end
			PH_PORT: res_valid = 1'b0;
			PH_BIT: begin
				res.action = ACT_PINS;
				res_valid  = (cur.port_choice == PORT_C) ? (rx == CH_5) : bit_ok;
			end
			default: begin
				if (rx == CH_T) begin
					res_valid     = 1'b1;
					res.action    = ACT_TX;
					res.data_byte = item.conv_reading[8:1];
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sim/serial_command_port_parser_tb.sv -----
`timescale 1ns / 1ps
module serial_command_port_parser_tb;
	import scp_pkg::*;

	localparam int ITEMS        = 800;
	localparam int HOLD_AT      = 120;   // results seen before the long receiver hold
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;  // cycles without any transaction
	localparam int DRAIN_CYCLES = 10;
	localparam int PRINT_CAP    = 50;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	serial_command_port_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	in_item_t  pending_bytes[$];
	out_item_t replies_due[$];
	int        errors = 0;
	int        bytes_sent = 0;
	int        replies_checked = 0;
	int        action_seen[5] = '{default: 0};

	// Parser state as the block should hold it
	phase_t     cur_phase = PH_IDLE;
	logic       set_pins = 1'b0;
	port_sel_t  port_sel = PORT_C;
	logic [4:0] chars_left = '0;
	logic [7:0] duty_lo = '0;
	logic [7:0] d_pins = '0;
	logic [7:0] b_pins = '0;
	logic       c5_pin = 1'b0;

	task automatic parse_rx_byte(input in_item_t it);
		out_item_t  r;
		logic [7:0] rx;
		logic [7:0] mask;
		bit         has_reply;
		bit         has_mask;
		r = '0;
		rx = it.rx_byte;
		has_reply = 0;
		has_mask = 0;
		mask = '0;
		case (cur_phase)
			PH_LINE: begin
				cur_phase = PH_IDLE;
				if (rx == CH_1 || rx == CH_2) begin
					chars_left = 5'(LINE_CHARS_DEF & 31);
					if (chars_left != 0)
						cur_phase = PH_CHARS;
					r.action = ACT_LINE;
					r.line_number = (rx == CH_2);
					has_reply = 1;
				end
			end
			PH_CHARS: begin
				chars_left = chars_left - 5'd1;
				if (chars_left == 0)
					cur_phase = PH_IDLE;
				r.action = ACT_CHAR;
				r.data_byte = rx;
				has_reply = 1;
			end
			PH_DUTY1: begin
				duty_lo = rx;
				cur_phase = PH_DUTY2;
			end
			PH_DUTY2: begin
				cur_phase = PH_IDLE;
				r.action = ACT_DUTY;
				r.duty_value = {1'b0, duty_lo} + {1'b0, rx};
				has_reply = 1;
			end
			PH_PORT: begin
				cur_phase = PH_BIT;
				if (rx == CH_UC)
					port_sel = PORT_C;
				else if (rx == CH_UD)
					port_sel = PORT_D;
				else if (rx == CH_UB)
					port_sel = PORT_B;
				else
					cur_phase = PH_IDLE;
			end
			PH_BIT: begin
				cur_phase = PH_IDLE;
				if (port_sel == PORT_C) begin
					if (rx == CH_5) begin
						c5_pin = set_pins;
						has_reply = 1;
					end
				end else begin
					if (rx == CH_T) begin
						mask = 8'hFF;
						has_mask = 1;
					end else if (rx >= CH_0 && rx <= CH_7) begin
						mask = 8'd1 << (rx - CH_0);
						has_mask = 1;
					end
					if (has_mask) begin
						if (port_sel == PORT_D)
							d_pins = set_pins ? (d_pins | mask) : (d_pins & ~mask);
						else
							b_pins = set_pins ? (b_pins | mask) : (b_pins & ~mask);
						has_reply = 1;
					end
				end
				r.action = ACT_PINS;
			end
			default: begin
				cur_phase = PH_IDLE;
				if (rx == CH_L) begin
					cur_phase = PH_LINE;
				end else if (rx == CH_T) begin
					r.action = ACT_TX;
					r.data_byte = it.conv_reading[8:1];
					has_reply = 1;
				end else if (rx == CH_C) begin
					cur_phase = PH_DUTY1;
				end else if (rx == CH_1 || rx == CH_0) begin
					set_pins = (rx == CH_1);
					cur_phase = PH_PORT;
				end
			end
		endcase
		if (has_reply) begin
			r.port_d_pins = d_pins;
			r.port_b_pins = b_pins;
			r.pin_c5 = c5_pin;
			replies_due.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Mostly short gaps, a few long ones, and stretches with none at all
	function automatic int idle_gap(inout int steady);
		int r;
		if (steady > 0) begin
			steady--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			steady = $urandom_range(20, 80);
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_char();
		logic [7:0] letters[11];
		letters = '{CH_L, CH_T, CH_C, CH_0, CH_1, CH_2, CH_5, CH_7, CH_UC, CH_UD, CH_UB};
		if ($urandom_range(0, 2) == 0)
			return letters[$urandom_range(0, 10)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_rx(input logic [7:0] b);
		in_item_t it;
		it.rx_byte = b;
		it.conv_reading = 10'($urandom_range(0, 1023));
		pending_bytes.push_back(it);
	endtask

	// Driver
	int send_gap = 0;
	int send_steady = 0;
	int g;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_rx_byte(in_data);
				bytes_sent++;
				g = idle_gap(send_steady);
				if (g == 0 && pending_bytes.size() != 0) begin
					in_data <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
					send_gap = g;
				end
			end else if (!in_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_bytes.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_bytes.pop_front();
				end
			end
		end
	end

	// Monitor
	int recv_stall = 0;
	int recv_steady = 0;
	int hold_left = 0;
	out_item_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result, action", out_data.action, -1);
				end else begin
					want = replies_due.pop_front();
					if (out_data.action !== want.action)
						report_mismatch("action", out_data.action, want.action);
					if (out_data.line_number !== want.line_number)
						report_mismatch("line_number", out_data.line_number, want.line_number);
					if (out_data.data_byte !== want.data_byte)
						report_mismatch("data_byte", out_data.data_byte, want.data_byte);
					if (out_data.duty_value !== want.duty_value)
						report_mismatch("duty_value", out_data.duty_value, want.duty_value);
					if (out_data.port_d_pins !== want.port_d_pins)
						report_mismatch("port_d_pins", out_data.port_d_pins, want.port_d_pins);
					if (out_data.port_b_pins !== want.port_b_pins)
						report_mismatch("port_b_pins", out_data.port_b_pins, want.port_b_pins);
					if (out_data.pin_c5 !== want.pin_c5)
						report_mismatch("pin_c5", out_data.pin_c5, want.pin_c5);
					if (want.action <= ACT_PINS)
						action_seen[want.action]++;
				end
				replies_checked++;
				// hold off long enough for the block to back up into its input
				if (replies_checked == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				recv_stall = idle_gap(recv_steady);
				out_ready <= (recv_stall == 0);
			end
		end
	end

	// Watchdog
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int useful;
		int kind;
		logic [7:0] port_letter;
		useful = 0;

		// Directed: field extremes, every command but the line command, and the malformed forms
		pending_bytes.push_back('{CH_T, 10'h3FF});
		pending_bytes.push_back('{CH_T, 10'h000});
		push_rx(CH_C); push_rx(8'hFF); push_rx(8'hFF);
		push_rx(CH_1); push_rx(CH_UD); push_rx(CH_T);
		push_rx(CH_0); push_rx(CH_UD); push_rx(8'h33);
		push_rx(CH_1); push_rx(CH_UB); push_rx(CH_7);
		push_rx(CH_1); push_rx(CH_UC); push_rx(CH_5);
		push_rx(8'hFF);                             // unknown command
		push_rx(CH_L); push_rx(8'h33);              // bad line digit
		push_rx(CH_1); push_rx(8'h58);              // bad port letter
		push_rx(CH_1); push_rx(CH_UD); push_rx(8'h38); // bit digit out of range
		push_rx(CH_1); push_rx(CH_UC); push_rx(8'h34); // C port bit other than five

		// Random: mostly well-formed commands with random content
		while (useful < ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				push_rx(CH_L);
				push_rx($urandom_range(0, 1) ? CH_2 : CH_1);
				for (int i = 0; i < LINE_CHARS_DEF; i++)
					push_rx(pick_char());
				useful += 2 + LINE_CHARS_DEF;
			end else if (kind < 28) begin
				push_rx(CH_T);
				useful += 1;
			end else if (kind < 45) begin
				push_rx(CH_C);
				push_rx(8'($urandom_range(0, 255)));
				push_rx(8'($urandom_range(0, 255)));
				useful += 3;
			end else if (kind < 80) begin
				push_rx($urandom_range(0, 1) ? CH_1 : CH_0);
				case ($urandom_range(0, 2))
					0: port_letter = CH_UC;
					1: port_letter = CH_UD;
					default: port_letter = CH_UB;
				endcase
				push_rx(port_letter);
				if (port_letter == CH_UC)
					push_rx($urandom_range(0, 3) != 0 ? CH_5 : pick_char());
				else if ($urandom_range(0, 4) == 0)
					push_rx($urandom_range(0, 1) ? CH_T : pick_char());
				else
					push_rx(CH_0 + 8'($urandom_range(0, 7)));
				useful += 3;
			end else if (kind < 90) begin
				// broken prefix, then whatever follows
				case ($urandom_range(0, 2))
					0: push_rx(CH_L);
					1: push_rx($urandom_range(0, 1) ? CH_1 : CH_0);
					default: begin
						push_rx(CH_1);
						push_rx($urandom_range(0, 1) ? CH_UD : CH_UB);
					end
				endcase
				push_rx(pick_char());
				useful += 2;
			end else begin
				push_rx(8'($urandom_range(0, 255)));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid || replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (replies_due.size() != 0)
			report_mismatch("results never delivered", 0, replies_due.size());
		$display("Run covered %0d received bytes and %0d checked results,",
			bytes_sent, replies_checked);
		$display("incl. one long output hold. Results by kind: line %0d, char %0d, tx %0d, duty %0d, pins %0d.",
			action_seen[0], action_seen[1], action_seen[2], action_seen[3], action_seen[4]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
